// ----- sv/dsp_pkg.sv -----
// Shared constants and a helper function for the double sphere projection block.
package dsp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int RAY_W      = 32;
    localparam int FOCAL_W    = 28;
    localparam int SHIFT_W    = 19;
    localparam int BLEND_W    = 17;
    localparam int COS_W      = 18;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 3 * RAY_W;
    localparam int M_TDATA_W  = 72;
    localparam int VIEW_BIT   = 2 * RAY_W;

    localparam logic signed [RAY_W-1:0] RAY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RAY_W-1:0] RAY_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_SHIFT = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF_FOV = 8'd6;

    function automatic logic [RAY_W-1:0] ray_mag(input logic signed [RAY_W-1:0] v);
        return v[RAY_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- sv/dsp_sqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
module dsp_sqrt #(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [RAD_W/2-1:0]    out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg   [ROOT_W+1];
    logic [REM_W-1:0]  rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg  [ROOT_W+1];
    logic [SIDE_W-1:0] side_reg  [ROOT_W+1];
    logic              valid_reg [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_stage
        logic [REM_W-1:0] rem_s;
        logic [REM_W-1:0] trial;
        logic             fits;

        assign rem_s = {rem_reg[k-1][ROOT_W-1:0], rad_reg[k-1][RAD_W-1 -: 2]};
        assign trial = {root_reg[k-1], 2'b01};
        assign fits  = rem_s >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= fits ? (rem_s - trial) : rem_s;
                root_reg[k] <= {root_reg[k-1][ROOT_W-2:0], fits};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

// ----- sv/dsp_div.sv -----
// Pipelined restoring divider for two numerators over a shared divisor, one bit per stage.
module dsp_div #(
    parameter int N_W    = 60,
    parameter int D_W    = 39,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [N_W-1:0]    in_num_a,
    input  logic [N_W-1:0]    in_num_b,
    input  logic [D_W-1:0]    in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [N_W-1:0]    out_quo_a,
    output logic [N_W-1:0]    out_quo_b,
    output logic [SIDE_W-1:0] out_side
);

    logic [N_W-1:0]    num_a_reg [N_W+1];
    logic [N_W-1:0]    num_b_reg [N_W+1];
    logic [D_W-1:0]    rem_a_reg [N_W+1];
    logic [D_W-1:0]    rem_b_reg [N_W+1];
    logic [D_W-1:0]    den_reg   [N_W+1];
    logic [SIDE_W-1:0] side_reg  [N_W+1];
    logic              valid_reg [N_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_a_reg[0] <= in_num_a;
            num_b_reg[0] <= in_num_b;
            rem_a_reg[0] <= '0;
            rem_b_reg[0] <= '0;
            den_reg[0]   <= in_den;
            side_reg[0]  <= in_side;
        end
    end

    for (genvar k = 1; k <= N_W; k++)
    begin : g_stage
        logic [D_W:0] ra_s;
        logic [D_W:0] rb_s;
        logic [D_W:0] den_x;
        logic         ga;
        logic         gb;

        assign den_x = {1'b0, den_reg[k-1]};
        assign ra_s  = {rem_a_reg[k-1], num_a_reg[k-1][N_W-1]};
        assign rb_s  = {rem_b_reg[k-1], num_b_reg[k-1][N_W-1]};
        assign ga    = ra_s >= den_x;
        assign gb    = rb_s >= den_x;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k] <= ga ? D_W'(ra_s - den_x) : ra_s[D_W-1:0];
                rem_b_reg[k] <= gb ? D_W'(rb_s - den_x) : rb_s[D_W-1:0];
                num_a_reg[k] <= {num_a_reg[k-1][N_W-2:0], ga};
                num_b_reg[k] <= {num_b_reg[k-1][N_W-2:0], gb};
                den_reg[k]   <= den_reg[k-1];
                side_reg[k]  <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[N_W];
    assign out_quo_a = num_a_reg[N_W];
    assign out_quo_b = num_b_reg[N_W];
    assign out_side  = side_reg[N_W];

endmodule

// ----- sv/double_sphere_project.sv -----
// Double sphere camera projection: one bearing in, one pixel with an in-view flag out.
// The block takes one item per cycle unless stalled as below; the two square roots and the
// divider each resolve one bit per register stage. A result waiting on the output stops
// intake as soon as the stage feeding the output register also holds an item; empty stages
// further up the pipeline are not filled during the stall.
module double_sphere_project
    import dsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // ray_x, ray_y, ray_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // pix_u, pix_v, in_view, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SQ_W    = 2 * RAY_W;
    localparam int SQXY_W  = 2 * RAY_W;
    localparam int D1_W    = RAY_W;
    localparam int XP_W    = SHIFT_W + D1_W + 1;
    localparam int CP_W    = COS_W + D1_W + 1;
    localparam int TS_W    = XP_W - FRAC_BITS;
    localparam int T_W     = (TS_W > RAY_W ? TS_W : RAY_W) + 1;
    localparam int L_W     = T_W / 2;
    localparam int H_W     = T_W - L_W;
    localparam int R_W     = T_W + 1;
    localparam int RAD2_W  = 2 * R_W;
    localparam int FV_W    = (RAY_W + FRAC_BITS > CP_W ? RAY_W + FRAC_BITS : CP_W) + 1;
    localparam int AL_W    = (BLEND_W > FRAC_BITS + 1) ? BLEND_W : FRAC_BITS + 1;
    localparam int OA_W    = FRAC_BITS + 2;
    localparam int PA_W    = AL_W + R_W;
    localparam int PB_W    = OA_W + T_W;
    localparam int S_W     = (PA_W > PB_W ? PA_W : PB_W) + 1;
    localparam int WS_W    = S_W - FRAC_BITS;
    localparam int DV_W    = WS_W - 1;
    localparam int N_W     = FOCAL_W + RAY_W;
    localparam int Q_W     = N_W + 1;
    localparam int U_W     = Q_W + 1;
    localparam int SIDE1_W = 3 * RAY_W + SQXY_W;
    localparam int SIDE2_W = 2 * RAY_W + T_W + 1;
    localparam int SIDE3_W = 6;

    localparam logic [AL_W-1:0] ONE_A = AL_W'(1) << FRAC_BITS;
    localparam logic signed [COS_W-1:0] COS_RST = COS_W'(-(longint'(1) << FRAC_BITS));

    logic [FOCAL_W-1:0]       focal_x_reg;
    logic [FOCAL_W-1:0]       focal_y_reg;
    logic [FOCAL_W-1:0]       center_x_reg;
    logic [FOCAL_W-1:0]       center_y_reg;
    logic signed [SHIFT_W-1:0] sphere_shift_reg;
    logic [BLEND_W-1:0]       blend_weight_reg;
    logic signed [COS_W-1:0]  cos_half_fov_reg;

    logic en;
    logic ld;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg      <= '0;
            focal_y_reg      <= '0;
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            sphere_shift_reg <= '0;
            blend_weight_reg <= '0;
            cos_half_fov_reg <= COS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FOCAL_X:      focal_x_reg      <= cfg_data[FOCAL_W-1:0];
                CFG_FOCAL_Y:      focal_y_reg      <= cfg_data[FOCAL_W-1:0];
                CFG_CENTER_X:     center_x_reg     <= cfg_data[FOCAL_W-1:0];
                CFG_CENTER_Y:     center_y_reg     <= cfg_data[FOCAL_W-1:0];
                CFG_SPHERE_SHIFT: sphere_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_BLEND_WEIGHT: blend_weight_reg <= cfg_data[BLEND_W-1:0];
                CFG_COS_HALF_FOV: cos_half_fov_reg <= cfg_data[COS_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [AL_W-1:0]         alpha_c;
    logic signed [OA_W-1:0]  oa;
    logic                    alpha_big;

    assign alpha_c   = (AL_W'(blend_weight_reg) > ONE_A) ? ONE_A : AL_W'(blend_weight_reg);
    assign oa        = OA_W'(ONE_A) - OA_W'(alpha_c);
    assign alpha_big = alpha_c > (ONE_A >> 1);

    // Stage A: squares of the input components.
    logic signed [RAY_W-1:0] in_x, in_y, in_z;
    logic [RAY_W-1:0]        in_xm, in_ym, in_zm;
    logic                    a_valid_reg;
    logic signed [RAY_W-1:0] a_x_reg, a_y_reg, a_z_reg;
    logic [SQ_W-1:0]         a_sqx_reg, a_sqy_reg, a_sqz_reg;

    assign in_x  = s_tdata[RAY_W-1:0];
    assign in_y  = s_tdata[2*RAY_W-1:RAY_W];
    assign in_z  = s_tdata[3*RAY_W-1:2*RAY_W];
    assign in_xm = ray_mag(in_x);
    assign in_ym = ray_mag(in_y);
    assign in_zm = ray_mag(in_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg   <= in_x;
            a_y_reg   <= in_y;
            a_z_reg   <= in_z;
            a_sqx_reg <= SQ_W'(in_xm) * SQ_W'(in_xm);
            a_sqy_reg <= SQ_W'(in_ym) * SQ_W'(in_ym);
            a_sqz_reg <= SQ_W'(in_zm) * SQ_W'(in_zm);
        end
    end

    // First radius.
    logic [SQXY_W-1:0]  a_sqxy;
    logic [SQ_W-1:0]    rad1;
    logic               r1_valid;
    logic [D1_W-1:0]    r1_root;
    logic [SIDE1_W-1:0] r1_side;

    assign a_sqxy = SQXY_W'(a_sqx_reg) + SQXY_W'(a_sqy_reg);
    assign rad1   = a_sqx_reg + a_sqy_reg + a_sqz_reg;

    dsp_sqrt #(
        .RAD_W  (SQ_W),
        .SIDE_W (SIDE1_W)
    ) u_sqrt1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_rad    (rad1),
        .in_side   ({a_x_reg, a_y_reg, a_z_reg, a_sqxy}),
        .out_valid (r1_valid),
        .out_root  (r1_root),
        .out_side  (r1_side)
    );

    // Stage C: products of the first radius.
    logic                    c_valid_reg;
    logic signed [RAY_W-1:0] c_x_reg, c_y_reg, c_z_reg;
    logic [SQXY_W-1:0]       c_sqxy_reg;
    logic signed [XP_W-1:0]  c_xp_reg;
    logic signed [CP_W-1:0]  c_cp_reg;
    logic signed [D1_W:0]    r1_root_s;

    assign r1_root_s = {1'b0, r1_root};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= r1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_x_reg    <= r1_side[SIDE1_W-1 -: RAY_W];
            c_y_reg    <= r1_side[SIDE1_W-RAY_W-1 -: RAY_W];
            c_z_reg    <= r1_side[SIDE1_W-2*RAY_W-1 -: RAY_W];
            c_sqxy_reg <= r1_side[SQXY_W-1:0];
            c_xp_reg   <= XP_W'(sphere_shift_reg) * XP_W'(r1_root_s);
            c_cp_reg   <= CP_W'(cos_half_fov_reg) * CP_W'(r1_root_s);
        end
    end

    // Stage D: shifted sphere center and the field-of-view test.
    logic                    d_valid_reg;
    logic signed [RAY_W-1:0] d_x_reg, d_y_reg;
    logic [SQXY_W-1:0]       d_sqxy_reg;
    logic signed [T_W-1:0]   d_t_reg;
    logic                    d_fov_reg;
    logic signed [FV_W-1:0]  zf;
    logic signed [FV_W-1:0]  cpf;

    assign zf  = FV_W'(c_z_reg) <<< FRAC_BITS;
    assign cpf = FV_W'(c_cp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_x_reg    <= c_x_reg;
            d_y_reg    <= c_y_reg;
            d_sqxy_reg <= c_sqxy_reg;
            d_t_reg    <= T_W'(c_xp_reg >>> FRAC_BITS) + T_W'(c_z_reg);
            d_fov_reg  <= zf <= cpf;
        end
    end

    // Stage E: square of t as two partial products.
    logic [T_W-1:0]          tmag;
    logic                    e_valid_reg;
    logic signed [RAY_W-1:0] e_x_reg, e_y_reg;
    logic [SQXY_W-1:0]       e_sqxy_reg;
    logic signed [T_W-1:0]   e_t_reg;
    logic                    e_fov_reg;
    logic [L_W+T_W-1:0]      e_plo_reg;
    logic [H_W+T_W-1:0]      e_phi_reg;

    assign tmag = d_t_reg[T_W-1] ? T_W'(-d_t_reg) : d_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_x_reg    <= d_x_reg;
            e_y_reg    <= d_y_reg;
            e_sqxy_reg <= d_sqxy_reg;
            e_t_reg    <= d_t_reg;
            e_fov_reg  <= d_fov_reg;
            e_plo_reg  <= (L_W+T_W)'(tmag[L_W-1:0]) * (L_W+T_W)'(tmag);
            e_phi_reg  <= (H_W+T_W)'(tmag[T_W-1:L_W]) * (H_W+T_W)'(tmag);
        end
    end

    // Second radius.
    logic [RAD2_W-1:0]  rad2;
    logic               r2_valid;
    logic [R_W-1:0]     r2_root;
    logic [SIDE2_W-1:0] r2_side;

    assign rad2 = RAD2_W'(e_sqxy_reg) + (RAD2_W'(e_phi_reg) << L_W) + RAD2_W'(e_plo_reg);

    dsp_sqrt #(
        .RAD_W  (RAD2_W),
        .SIDE_W (SIDE2_W)
    ) u_sqrt2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .in_rad    (rad2),
        .in_side   ({e_x_reg, e_y_reg, e_t_reg, e_fov_reg}),
        .out_valid (r2_valid),
        .out_root  (r2_root),
        .out_side  (r2_side)
    );

    // Stage G: blend products and the focal numerators.
    logic signed [RAY_W-1:0] r2_x, r2_y;
    logic signed [T_W-1:0]   r2_t;
    logic                    g_valid_reg;
    logic [PA_W-1:0]         g_pa_reg;
    logic signed [PB_W-1:0]  g_pb_reg;
    logic [N_W-1:0]          g_nu_reg, g_nv_reg;
    logic                    g_sx_reg, g_sy_reg, g_zx_reg, g_zy_reg, g_fov_reg;

    assign r2_x = r2_side[SIDE2_W-1 -: RAY_W];
    assign r2_y = r2_side[SIDE2_W-RAY_W-1 -: RAY_W];
    assign r2_t = r2_side[T_W:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= r2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_pa_reg  <= PA_W'(alpha_c) * PA_W'(r2_root);
            g_pb_reg  <= PB_W'(oa) * PB_W'(r2_t);
            g_nu_reg  <= N_W'(focal_x_reg) * N_W'(ray_mag(r2_x));
            g_nv_reg  <= N_W'(focal_y_reg) * N_W'(ray_mag(r2_y));
            g_sx_reg  <= r2_x[RAY_W-1];
            g_sy_reg  <= r2_y[RAY_W-1];
            g_zx_reg  <= r2_x == '0;
            g_zy_reg  <= r2_y == '0;
            g_fov_reg <= r2_side[0];
        end
    end

    // Stage H: denominator.
    logic signed [S_W-1:0]  wsum;
    logic                   h_valid_reg;
    logic signed [WS_W-1:0] h_w_reg;
    logic [N_W-1:0]         h_nu_reg, h_nv_reg;
    logic                   h_sx_reg, h_sy_reg, h_zx_reg, h_zy_reg, h_fov_reg;
    logic                   wpos;
    logic [DV_W-1:0]        den;

    assign wsum = S_W'(g_pa_reg) + S_W'(g_pb_reg);
    assign wpos = !h_w_reg[WS_W-1] && (h_w_reg != '0);
    assign den  = wpos ? h_w_reg[DV_W-1:0] : DV_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_w_reg   <= WS_W'(wsum >>> FRAC_BITS);
            h_nu_reg  <= g_nu_reg;
            h_nv_reg  <= g_nv_reg;
            h_sx_reg  <= g_sx_reg;
            h_sy_reg  <= g_sy_reg;
            h_zx_reg  <= g_zx_reg;
            h_zy_reg  <= g_zy_reg;
            h_fov_reg <= g_fov_reg;
        end
    end

    logic               dv_valid;
    logic [N_W-1:0]     dv_qu, dv_qv;
    logic [SIDE3_W-1:0] dv_side;

    dsp_div #(
        .N_W    (N_W),
        .D_W    (DV_W),
        .SIDE_W (SIDE3_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid_reg),
        .in_num_a  (h_nu_reg),
        .in_num_b  (h_nv_reg),
        .in_den    (den),
        .in_side   ({h_sx_reg, h_sy_reg, h_zx_reg, h_zy_reg, wpos, h_fov_reg}),
        .out_valid (dv_valid),
        .out_quo_a (dv_qu),
        .out_quo_b (dv_qv),
        .out_side  (dv_side)
    );

    // Stage K: signed quotient plus principal point.
    logic signed [Q_W-1:0] qsu, qsv;
    logic                  k_valid_reg;
    logic signed [U_W-1:0] k_u_reg, k_v_reg;
    logic [SIDE3_W-1:0]    k_side_reg;

    assign qsu = dv_side[5] ? -Q_W'(dv_qu) : Q_W'(dv_qu);
    assign qsv = dv_side[4] ? -Q_W'(dv_qv) : Q_W'(dv_qv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            k_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_u_reg    <= U_W'(qsu) + U_W'(center_x_reg);
            k_v_reg    <= U_W'(qsv) + U_W'(center_y_reg);
            k_side_reg <= dv_side;
        end
    end

    // Output register: bounds, saturation and the in-view flag.
    function automatic logic [RAY_W-1:0] sat_ray(input logic signed [U_W-1:0] v);
        logic signed [U_W-1:0] hi;
        logic signed [U_W-1:0] lo;
        hi = U_W'(RAY_MAX);
        lo = U_W'(RAY_MIN);
        if (v > hi)
        begin
            return RAY_MAX;
        end
        if (v < lo)
        begin
            return RAY_MIN;
        end
        return v[RAY_W-1:0];
    endfunction

    logic signed [U_W-1:0] two_cx, two_cy;
    logic                  k_sx, k_sy, k_zx, k_zy, k_wpos, k_fov;
    logic                  out_of_image;
    logic [RAY_W-1:0]      u_next, v_next;
    logic                  view_next;
    logic                  out_valid_reg;
    logic [RAY_W-1:0]      u_reg, v_reg;
    logic                  view_reg;

    assign {k_sx, k_sy, k_zx, k_zy, k_wpos, k_fov} = k_side_reg;
    assign two_cx = U_W'(center_x_reg) <<< 1;
    assign two_cy = U_W'(center_y_reg) <<< 1;
    assign out_of_image = (k_u_reg > two_cx) || k_u_reg[U_W-1]
                       || (k_v_reg > two_cy) || k_v_reg[U_W-1];

    always_comb
    begin
        if (k_wpos)
        begin
            u_next    = sat_ray(k_u_reg);
            v_next    = sat_ray(k_v_reg);
            view_next = !out_of_image && !(alpha_big && k_fov);
        end
        else
        begin
            u_next    = k_sx ? RAY_MIN : (k_zx ? RAY_W'(center_x_reg) : RAY_MAX);
            v_next    = k_sy ? RAY_MIN : (k_zy ? RAY_W'(center_y_reg) : RAY_MAX);
            view_next = 1'b0;
        end
    end

    assign ld = !out_valid_reg || m_tready;
    assign en = ld || !k_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            out_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            view_reg <= view_next;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - 2*RAY_W - 1)'(0), view_reg, v_reg, u_reg};

endmodule

// ----- sv/dsp_checker.sv -----
// Port-level checks for the double sphere projection block and their binding.
module dsp_checker
    import dsp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_intake_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled although the output can move");

    a_view_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[VIEW_BIT] |-> !m_tdata[RAY_W-1] && !m_tdata[2*RAY_W-1])
        else $error("in-view pixel with negative coordinate");

endmodule

bind double_sphere_project dsp_checker u_dsp_checker (.*);

// ----- tb/tb_double_sphere_project.sv -----
// Self-checking testbench for the double sphere projection block, predicting every pixel.
`timescale 1ns / 1ps

module tb_double_sphere_project;
    import dsp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;
    localparam longint ONE_Q = 64'sd65536;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 8;
    localparam int RAYS_PER_PHASE = 210;

    typedef struct {
        logic signed [RAY_W-1:0] u;
        logic signed [RAY_W-1:0] v;
        logic                    view;
    } pixel_t;

    typedef struct {
        int x;
        int y;
        int z;
        bit typed;
        int u;
        int v;
        bit view;
    } ray_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    longint focal_x, focal_y, center_x, center_y, shift_xi, blend, cos_fov;
    pixel_t pending_pixels[$];
    int errors = 0;
    int cycles = 0;
    int rays_taken = 0;
    int regs_written = 0;
    int rx_stall_pct = 0;
    int tx_idle_pct = 0;
    bit rx_hold = 1'b0;
    bit next_typed = 1'b0;
    pixel_t next_typed_pixel;

    double_sphere_project uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint root_floor(logic [127:0] s);
        logic [127:0] r;
        logic [127:0] c;
        r = '0;
        for (int b = 37; b >= 0; b--)
        begin
            c = r | (128'd1 << b);
            if (c * c <= s)
                r = c;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic pixel_t project_ray(logic signed [RAY_W-1:0] rx,
                                           logic signed [RAY_W-1:0] ry,
                                           logic signed [RAY_W-1:0] rz);
        longint x, y, z, alpha, d1, d2, t, w, u, v;
        logic signed [127:0] tw;
        logic [127:0] sq;
        pixel_t p;
        bit ok;
        x = rx;
        y = ry;
        z = rz;
        alpha = (blend > ONE_Q) ? ONE_Q : blend;
        sq = 128'(x * x) + 128'(y * y) + 128'(z * z);
        d1 = root_floor(sq);
        t = ((shift_xi * d1) >>> 16) + z;
        tw = t;
        sq = 128'(x * x) + 128'(y * y) + 128'(tw * tw);
        d2 = root_floor(sq);
        w = (alpha * d2 + (ONE_Q - alpha) * t) >>> 16;
        ok = 1'b1;
        if (w <= 0)
        begin
            ok = 1'b0;
            u = (x > 0) ? longint'(RAY_MAX) : ((x < 0) ? longint'(RAY_MIN) : center_x);
            v = (y > 0) ? longint'(RAY_MAX) : ((y < 0) ? longint'(RAY_MIN) : center_y);
        end
        else
        begin
            u = (focal_x * x) / w + center_x;
            v = (focal_y * y) / w + center_y;
            if (u > 2 * center_x || u < 0 || v > 2 * center_y || v < 0)
                ok = 1'b0;
            if (alpha > ONE_Q / 2 && z * ONE_Q <= cos_fov * d1)
                ok = 1'b0;
        end
        if (u > longint'(RAY_MAX)) u = RAY_MAX;
        if (u < longint'(RAY_MIN)) u = RAY_MIN;
        if (v > longint'(RAY_MAX)) v = RAY_MAX;
        if (v < longint'(RAY_MIN)) v = RAY_MIN;
        p.u = u[31:0];
        p.v = v[31:0];
        p.view = ok;
        return p;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                regs_written++;
                case (cfg_index)
                    CFG_FOCAL_X:      focal_x = cfg_data[27:0];
                    CFG_FOCAL_Y:      focal_y = cfg_data[27:0];
                    CFG_CENTER_X:     center_x = cfg_data[27:0];
                    CFG_CENTER_Y:     center_y = cfg_data[27:0];
                    CFG_SPHERE_SHIFT: shift_xi = $signed(cfg_data[SHIFT_W-1:0]);
                    CFG_BLEND_WEIGHT: blend = cfg_data[BLEND_W-1:0];
                    CFG_COS_HALF_FOV: cos_fov = $signed(cfg_data[COS_W-1:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                rays_taken++;
                if (next_typed)
                    pending_pixels.push_back(next_typed_pixel);
                else
                    pending_pixels.push_back(project_ray(s_tdata[31:0], s_tdata[63:32],
                                                         s_tdata[95:64]));
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_pixels.size() == 0)
                    report("unexpected pixel", m_tdata[31:0], 0);
                else
                begin
                    want = pending_pixels.pop_front();
                    if ($signed(m_tdata[31:0]) != want.u)
                        report("pix_u", $signed(m_tdata[31:0]), want.u);
                    if ($signed(m_tdata[63:32]) != want.v)
                        report("pix_v", $signed(m_tdata[63:32]), want.v);
                    if (m_tdata[VIEW_BIT] != want.view)
                        report("in_view", m_tdata[VIEW_BIT], want.view);
                end
            end
        end
    end

    always @(negedge clk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    task automatic hold_output(int n);
        rx_hold = 1'b1;
        repeat (n) @(posedge clk);
        rx_hold = 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_ray(int x, int y, int z, bit typed, pixel_t typed_pixel);
        int seen;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        next_typed = typed;
        next_typed_pixel = typed_pixel;
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        seen = rays_taken;
        do @(negedge clk); while (rays_taken == seen);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        int seen;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[31:0];
        seen = regs_written;
        do @(negedge clk); while (regs_written == seen);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (160) @(negedge clk);
    endtask

    task automatic load_camera(longint fx, longint fy, longint cx, longint cy,
                               longint xi, longint a, longint c);
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_SPHERE_SHIFT, xi);
        write_reg(CFG_BLEND_WEIGHT, a);
        write_reg(CFG_COS_HALF_FOV, c);
    endtask

    function automatic int pick_edge();
        case ($urandom_range(4))
            0: return RAY_MAX;
            1: return RAY_MIN;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    ray_row_t directed_rays[] = '{
        '{0, 0, 0, 1, 0, 0, 0},
        '{1, -1, 0, 1, RAY_MAX, RAY_MIN, 0},
        '{0, 0, 65536, 1, 0, 0, 1},
        '{0, 0, -65536, 1, 0, 0, 0},
        '{RAY_MAX, 0, 0, 1, RAY_MAX, 0, 0},
        '{RAY_MIN, RAY_MIN, 0, 1, RAY_MIN, RAY_MIN, 0},
        '{RAY_MAX, RAY_MAX, RAY_MAX, 0, 0, 0, 0},
        '{RAY_MIN, RAY_MIN, RAY_MIN, 0, 0, 0, 0},
        '{0, 0, RAY_MAX, 0, 0, 0, 0},
        '{0, 0, RAY_MIN, 0, 0, 0, 0},
        '{65536, 65536, 65536, 0, 0, 0, 0},
        '{-1, -1, 1, 0, 0, 0, 0},
        '{RAY_MAX, RAY_MIN, 65536, 0, 0, 0, 0}
    };

    initial
    begin
        pixel_t tp;
        int x, y, z, mode;
        focal_x = 0; focal_y = 0; center_x = 0; center_y = 0;
        shift_xi = 0; blend = 0; cos_fov = -ONE_Q;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rays[i])
        begin
            tp.u = directed_rays[i].u;
            tp.v = directed_rays[i].v;
            tp.view = directed_rays[i].view;
            send_ray(directed_rays[i].x, directed_rays[i].y, directed_rays[i].z,
                     directed_rays[i].typed, tp);
        end
        drain_pixels();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        load_camera(500 << 16, 480 << 16, 320 << 16, 240 << 16, 0, 0, -ONE_Q);
        for (int i = 0; i < 6; i++)
            send_ray(directed_rays[6 + i].x, directed_rays[6 + i].y,
                     directed_rays[6 + i].z, 1'b0, tp);
        drain_pixels();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_camera(500 << 16, 500 << 16, 320 << 16, 240 << 16, 0, 0, -ONE_Q);
                1: load_camera(28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF, 28'hFFF_FFFF,
                               262143, ONE_Q, ONE_Q);
                2: load_camera(0, 0, 0, 0, -262144, 131071, -131072);
                3: load_camera(300 << 16, 310 << 16, 400 << 16, 300 << 16,
                               40000, 39321, 0);
                4: load_camera(28'hFFF_FFFF, 1, 1, 28'hFFF_FFFF, 0, ONE_Q / 2, 131071);
                default: load_camera($urandom_range(2000, 50) << 16,
                                     $urandom_range(2000, 50) << 16,
                                     $urandom_range(1000, 20) << 16,
                                     $urandom_range(1000, 20) << 16,
                                     longint'($urandom_range(524287)) - 262144,
                                     $urandom_range(ONE_Q),
                                     longint'($urandom_range(131072)) - ONE_Q);
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            if (ph == 0 || ph == 4)
                fork
                    hold_output(600);
                join_none
            for (int n = 0; n < RAYS_PER_PHASE; n++)
            begin
                mode = $urandom_range(9);
                if (mode < 2)
                begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end
                else if (mode == 2)
                begin
                    x = pick_edge();
                    y = pick_edge();
                    z = pick_edge();
                end
                else
                begin
                    x = int'($urandom_range(1 << 19)) - (1 << 18);
                    y = int'($urandom_range(1 << 19)) - (1 << 18);
                    z = int'($urandom_range(1 << 18)) - (1 << 14);
                end
                send_ray(x, y, z, 1'b0, tp);
            end
            drain_pixels();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
